// ===== hw/rtl/html_link_attribute_extractor_assert.svh =====
// Assertion macros shared by the link extractor RTL.
`ifndef HTML_LINK_ATTRIBUTE_EXTRACTOR_ASSERT_SVH
`define HTML_LINK_ATTRIBUTE_EXTRACTOR_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define HLAE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("hlae assertion failed");
// Check a property on every clock edge, reset included.
`define HLAE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hlae assertion failed");
`else
`define HLAE_ASSERT(lbl, clk, rst_n, prop)
`define HLAE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/hlae_pkg.sv =====
// Types and constants of the link extractor.
package hlae_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_C     = 8'h63;

    // Window contents that precede the final keyword letter, newest byte low.
    localparam logic [31:0] WIN_HREF = {CH_SPACE, CH_H, CH_R, CH_E};
    localparam logic [23:0] WIN_SRC  = {CH_SPACE, CH_S, CH_R};

    localparam logic KIND_HREF = 1'b0;
    localparam logic KIND_SRC  = 1'b1;

    typedef enum logic [1:0] {
        PH_SCAN       = 2'd0,
        PH_SEEK_EQUAL = 2'd1,
        PH_SEEK_QUOTE = 2'd2,
        PH_LINK       = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] page_byte;
        logic       page_last;
    } t_page_word;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       link_end;
        logic       attr_kind;
    } t_link_word;

endpackage

// ===== hw/rtl/hlae_parser.sv =====
// Parser state and per-byte decode of the link extractor.
`include "html_link_attribute_extractor_assert.svh"

module hlae_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  hlae_pkg::t_page_word i_word,
    output logic                o_result_valid,
    output hlae_pkg::t_link_word o_result
);

    hlae_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_recent, n_recent;
    logic             r_kind, n_kind;

    logic is_quote;
    assign is_quote = (i_word.page_byte == hlae_pkg::CH_QUOTE);

    // Next state.
    always_comb begin
        n_phase  = r_phase;
        n_recent = r_recent;
        n_kind   = r_kind;
        case (r_phase)
            hlae_pkg::PH_SEEK_EQUAL: begin
                if (i_word.page_byte == hlae_pkg::CH_EQUAL) begin
                    n_phase = hlae_pkg::PH_SEEK_QUOTE;
                end
            end
            hlae_pkg::PH_SEEK_QUOTE: begin
                if (is_quote) begin
                    n_phase = hlae_pkg::PH_LINK;
                end
            end
            hlae_pkg::PH_LINK: begin
                if (is_quote) begin
                    n_phase = hlae_pkg::PH_SCAN;
                end
            end
            hlae_pkg::PH_SCAN: begin
                if (i_word.page_byte == hlae_pkg::CH_F && r_recent == hlae_pkg::WIN_HREF) begin
                    n_kind  = hlae_pkg::KIND_HREF;
                    n_phase = hlae_pkg::PH_SEEK_EQUAL;
                end else if (i_word.page_byte == hlae_pkg::CH_C
                             && r_recent[23:0] == hlae_pkg::WIN_SRC) begin
                    n_kind  = hlae_pkg::KIND_SRC;
                    n_phase = hlae_pkg::PH_SEEK_EQUAL;
                end else begin
                    n_recent = {r_recent[23:0], i_word.page_byte};
                end
            end
            default: begin
                n_phase = hlae_pkg::PH_SCAN;
            end
        endcase
        // Clear the window on every phase change.
        if (n_phase != r_phase) begin
            n_recent = '0;
        end
        // Drop everything after the last byte of a page.
        if (i_word.page_last) begin
            n_phase  = hlae_pkg::PH_SCAN;
            n_recent = '0;
            n_kind   = hlae_pkg::KIND_HREF;
        end
    end

    // Result decode.
    always_comb begin
        o_result_valid     = 1'b0;
        o_result.link_byte = i_word.page_byte;
        o_result.link_end  = 1'b0;
        o_result.attr_kind = r_kind;
        case (r_phase)
            hlae_pkg::PH_LINK: begin
                o_result_valid = 1'b1;
                if (is_quote) begin
                    o_result.link_byte = '0;
                    o_result.link_end  = 1'b1;
                end
            end
            default: begin
                o_result_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hlae_pkg::PH_SCAN;
            r_recent <= '0;
            r_kind   <= hlae_pkg::KIND_HREF;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_kind   <= n_kind;
        end
    end

    `HLAE_ASSERT(a_page_end_resets, i_clk, i_rst_n, (i_advance && i_word.page_last) |=> (r_phase == hlae_pkg::PH_SCAN && r_recent == '0 && r_kind == hlae_pkg::KIND_HREF))
    `HLAE_ASSERT(a_phase_change_clears, i_clk, i_rst_n, (i_advance && n_phase != r_phase) |=> (r_recent == '0))
    `HLAE_ASSERT(a_window_only_in_scan, i_clk, i_rst_n, (r_phase != hlae_pkg::PH_SCAN) |-> (r_recent == '0))

endmodule

// ===== hw/rtl/hlae_out_slot.sv =====
// Result register between the parser and the output channel.
module hlae_out_slot (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  hlae_pkg::t_link_word i_word,
    input  logic                 i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output hlae_pkg::t_link_word o_word
);

    logic                 r_valid, n_valid;
    hlae_pkg::t_link_word r_word;

    // Free when empty or being drained this cycle.
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/html_link_attribute_extractor.sv =====
// Top level of the link extractor: input register, parser, result register.
//
//  channel | direction | handshake                      | word
//  page    | in        | i_page_valid / o_page_ready    | i_page (t_page_word)
//  link    | out       | o_link_valid / i_link_ready    | o_link (t_link_word)
//
// One page byte a cycle when the link side keeps up; each byte is held
// in the input register, is decoded by the parser as it moves on, and
// any link word it yields is loaded into the result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to keyword scan. A stalled link side holds the result register;
// the input register then holds one byte and the page side stalls next.
`include "html_link_attribute_extractor_assert.svh"

module html_link_attribute_extractor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_page_valid,
    output logic                 o_page_ready,
    input  hlae_pkg::t_page_word i_page,
    output logic                 o_link_valid,
    input  logic                 i_link_ready,
    output hlae_pkg::t_link_word o_link
);

    logic                 r_in_valid;
    hlae_pkg::t_page_word r_in;
    logic                 out_free;
    logic                 advance;
    logic                 result_valid;
    hlae_pkg::t_link_word result;

    // Advance the held byte whenever the result register can take its word.
    assign advance      = r_in_valid && out_free;
    assign o_page_ready = !r_in_valid || advance;

    // Input register: load on accept, drop when advanced without refill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_page_ready) begin
            r_in_valid <= i_page_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_page_valid && o_page_ready) begin
            r_in <= i_page;
        end
    end

    hlae_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_word         (r_in),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    hlae_out_slot u_out_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && result_valid),
        .i_word  (result),
        .i_ready (i_link_ready),
        .o_free  (out_free),
        .o_valid (o_link_valid),
        .o_word  (o_link)
    );

    `HLAE_ASSERT(a_stall_means_held, i_clk, i_rst_n, (!o_page_ready) |-> (r_in_valid && o_link_valid))
    `HLAE_ASSERT(a_held_byte_kept, i_clk, i_rst_n, (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
    `HLAE_ASSERT(a_result_lands, i_clk, i_rst_n, (advance && result_valid) |=> o_link_valid)

endmodule

// ===== tb/html_link_attribute_extractor_tb.sv =====
// Self-checking testbench of html_link_attribute_extractor: directed links, random pages.
module html_link_attribute_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Two register stages between an accepted page word and its link word.
    localparam int LINK_LATENCY = 2;
    // Abort limit for a hung run; leave a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_page_valid;
    logic                 o_page_ready;
    hlae_pkg::t_page_word i_page;
    logic                 o_link_valid;
    logic                 i_link_ready;
    hlae_pkg::t_link_word o_link;

    html_link_attribute_extractor DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page_valid (i_page_valid),
        .o_page_ready (o_page_ready),
        .i_page       (i_page),
        .o_link_valid (o_link_valid),
        .i_link_ready (i_link_ready),
        .o_link       (o_link)
    );

    // Parser shadow: keyword window, phase and kind of the open link.
    logic [31:0]      scan_window;
    hlae_pkg::t_phase parse_state;
    logic             link_kind;

    // Link words predicted but not yet seen on the output, oldest first.
    hlae_pkg::t_link_word link_words_due[$];
    hlae_pkg::t_link_word link_word_seen;
    hlae_pkg::t_link_word link_word_due;

    int unsigned page_idle_pct;
    int unsigned link_stall_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advance the shadow parser by one page word; return 1 when it yields a link word.
    function automatic bit parse_page_word(input hlae_pkg::t_page_word w,
                                           output hlae_pkg::t_link_word lw);
        bit emits;
        emits = 1'b0;
        lw    = '0;
        case (parse_state)
            hlae_pkg::PH_SEEK_EQUAL: begin
                if (w.page_byte == hlae_pkg::CH_EQUAL) begin
                    parse_state = hlae_pkg::PH_SEEK_QUOTE;
                    scan_window = '0;
                end
            end
            hlae_pkg::PH_SEEK_QUOTE: begin
                if (w.page_byte == hlae_pkg::CH_QUOTE) begin
                    parse_state = hlae_pkg::PH_LINK;
                    scan_window = '0;
                end
            end
            hlae_pkg::PH_LINK: begin
                // Closing quote yields the end marker with no byte; anything else is link text.
                emits        = 1'b1;
                lw.attr_kind = link_kind;
                if (w.page_byte == hlae_pkg::CH_QUOTE) begin
                    lw.link_end = 1'b1;
                    parse_state = hlae_pkg::PH_SCAN;
                    scan_window = '0;
                end else begin
                    lw.link_byte = w.page_byte;
                end
            end
            default: begin
                // Match on the final keyword letter against the preceding window.
                if (w.page_byte == hlae_pkg::CH_F && scan_window == hlae_pkg::WIN_HREF) begin
                    link_kind   = hlae_pkg::KIND_HREF;
                    parse_state = hlae_pkg::PH_SEEK_EQUAL;
                    scan_window = '0;
                end else if (w.page_byte == hlae_pkg::CH_C
                             && scan_window[23:0] == hlae_pkg::WIN_SRC) begin
                    link_kind   = hlae_pkg::KIND_SRC;
                    parse_state = hlae_pkg::PH_SEEK_EQUAL;
                    scan_window = '0;
                end else begin
                    scan_window = {scan_window[23:0], w.page_byte};
                end
            end
        endcase
        // End of page drops whatever is open, even an unterminated link.
        if (w.page_last) begin
            scan_window = '0;
            parse_state = hlae_pkg::PH_SCAN;
            link_kind   = hlae_pkg::KIND_HREF;
        end
        return emits;
    endfunction

    // Offer one page word, idling at random first; predict at the accepting edge.
    // Valid is left high afterwards so back-to-back words never lower and raise it in one step.
    task automatic send_page_word(input hlae_pkg::t_page_word w);
        hlae_pkg::t_link_word lw;
        if (page_idle_pct != 0 && $urandom_range(99) < page_idle_pct) begin
            i_page_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < page_idle_pct);
        end
        i_page_valid <= 1'b1;
        i_page       <= w;
        do @(posedge i_clk); while (!o_page_ready);
        if (parse_page_word(w, lw))
            link_words_due = {link_words_due, lw};
    endtask

    // Send a run of bytes; mark the final one as end of page when asked.
    task automatic send_page_text(input logic [7:0] text[$], input bit close_page);
        hlae_pkg::t_page_word w;
        foreach (text[i]) begin
            w.page_byte = text[i];
            w.page_last = close_page && (i == text.size() - 1);
            send_page_word(w);
        end
    endtask

    // Drop valid, then hold until every link word has come and the pipe has emptied.
    task automatic wait_link_idle();
        i_page_valid <= 1'b0;
        while (link_words_due.size() != 0) @(posedge i_clk);
        repeat (LINK_LATENCY + 2) @(posedge i_clk);
    endtask

    // Noise byte: half fully random, half drawn from the bytes the parser reacts to.
    function automatic logic [7:0] pick_page_byte();
        logic [7:0] hot[9];
        hot = '{hlae_pkg::CH_SPACE, hlae_pkg::CH_H, hlae_pkg::CH_R, hlae_pkg::CH_E,
                hlae_pkg::CH_F, hlae_pkg::CH_S, hlae_pkg::CH_C, hlae_pkg::CH_EQUAL,
                hlae_pkg::CH_QUOTE};
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(255));
        return hot[$urandom_range(8)];
    endfunction

    // Extremes of link text, both keywords, empty link, end of page on a quote,
    // an unterminated link and a keyword split across two pages.
    task automatic test_directed_links();
        logic [7:0] text[$];
        text = '{hlae_pkg::CH_SPACE, hlae_pkg::CH_H, hlae_pkg::CH_R, hlae_pkg::CH_E,
                 hlae_pkg::CH_F, hlae_pkg::CH_EQUAL, hlae_pkg::CH_QUOTE, 8'hFF, 8'h00,
                 hlae_pkg::CH_QUOTE};
        send_page_text(text, 1'b0);
        text = '{hlae_pkg::CH_SPACE, hlae_pkg::CH_S, hlae_pkg::CH_R, hlae_pkg::CH_C,
                 hlae_pkg::CH_EQUAL, hlae_pkg::CH_QUOTE, hlae_pkg::CH_QUOTE};
        send_page_text(text, 1'b1);
        text = '{hlae_pkg::CH_SPACE, hlae_pkg::CH_S, hlae_pkg::CH_R, hlae_pkg::CH_C,
                 hlae_pkg::CH_EQUAL, hlae_pkg::CH_QUOTE, 8'h7A};
        send_page_text(text, 1'b1);
        // The space ends a page, so the following src must not match.
        text = '{hlae_pkg::CH_SPACE};
        send_page_text(text, 1'b1);
        text = '{hlae_pkg::CH_S, hlae_pkg::CH_R, hlae_pkg::CH_C, hlae_pkg::CH_EQUAL,
                 hlae_pkg::CH_QUOTE, hlae_pkg::CH_QUOTE};
        send_page_text(text, 1'b1);
    endtask

    // Random pages: mostly well-formed attributes with random content, plus noise,
    // missing closing quotes and pages cut short at random.
    task automatic test_random_pages(input int unsigned n_words);
        logic [7:0]  text[$];
        logic [7:0]  b;
        int unsigned sent;
        sent = 0;
        while (sent < n_words) begin
            text.delete();
            repeat ($urandom_range(1, 4)) begin
                repeat ($urandom_range(0, 6)) text = {text, pick_page_byte()};
                if ($urandom_range(9) < 8) begin
                    text = {text, hlae_pkg::CH_SPACE};
                    if ($urandom_range(1) == 0) begin
                        text = {text, hlae_pkg::CH_H, hlae_pkg::CH_R, hlae_pkg::CH_E,
                                hlae_pkg::CH_F};
                    end else begin
                        text = {text, hlae_pkg::CH_S, hlae_pkg::CH_R, hlae_pkg::CH_C};
                    end
                    repeat ($urandom_range(0, 2)) begin
                        b = pick_page_byte();
                        text = {text, (b == hlae_pkg::CH_EQUAL ? hlae_pkg::CH_SPACE : b)};
                    end
                    text = {text, hlae_pkg::CH_EQUAL};
                    repeat ($urandom_range(0, 2)) begin
                        b = pick_page_byte();
                        text = {text, (b == hlae_pkg::CH_QUOTE ? hlae_pkg::CH_SPACE : b)};
                    end
                    text = {text, hlae_pkg::CH_QUOTE};
                    repeat ($urandom_range(0, 8)) begin
                        b = 8'($urandom_range(255));
                        text = {text, (b == hlae_pkg::CH_QUOTE ? hlae_pkg::CH_E : b)};
                    end
                    if ($urandom_range(9) != 0)
                        text = {text, hlae_pkg::CH_QUOTE};
                end
            end
            if (text.size() == 0)
                text = {text, pick_page_byte()};
            // Cut the page short now and then so it ends in any phase.
            if ($urandom_range(7) == 0)
                text = text[0 : $urandom_range(text.size() - 1)];
            send_page_text(text, 1'b1);
            sent += text.size();
        end
    endtask

    // Compare each accepted link word with the oldest prediction; drive ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_link_valid && i_link_ready) begin
            link_word_seen = o_link;
            if (link_words_due.size() == 0) begin
                $display("%0t unexpected link word: expected none actual %h",
                         $time, link_word_seen);
                mismatch_count++;
            end else begin
                link_word_due = link_words_due.pop_front();
                if (link_word_seen.link_byte !== link_word_due.link_byte) begin
                    $display("%0t link_byte expected %02h actual %02h", $time,
                             link_word_due.link_byte, link_word_seen.link_byte);
                    mismatch_count++;
                end
                if (link_word_seen.link_end !== link_word_due.link_end) begin
                    $display("%0t link_end expected %0b actual %0b", $time,
                             link_word_due.link_end, link_word_seen.link_end);
                    mismatch_count++;
                end
                if (link_word_seen.attr_kind !== link_word_due.attr_kind) begin
                    $display("%0t attr_kind expected %0b actual %0b", $time,
                             link_word_due.attr_kind, link_word_seen.attr_kind);
                    mismatch_count++;
                end
            end
        end
        i_link_ready <= ($urandom_range(99) >= link_stall_pct);
    end

    // Count cycles and abort a run that hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_page_valid   = 1'b0;
        i_page         = '0;
        page_idle_pct  = 0;
        link_stall_pct = 0;
        mismatch_count = 0;
        scan_window    = '0;
        parse_state    = hlae_pkg::PH_SCAN;
        link_kind      = hlae_pkg::KIND_HREF;

        // Hold reset, then release it once for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_links();
        wait_link_idle();

        // Sender idles lightly while the receiver stalls heavily.
        page_idle_pct  = 17;
        link_stall_pct = 57;
        test_random_pages(630);
        wait_link_idle();

        // Swap: sender idles heavily, receiver stalls lightly.
        page_idle_pct  = 57;
        link_stall_pct = 17;
        test_random_pages(630);
        wait_link_idle();

        // Full rate on both sides.
        page_idle_pct  = 0;
        link_stall_pct = 0;
        test_random_pages(630);
        wait_link_idle();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
